// ----- src/hashed_glitch_row_generator_macros.svh -----
// assertion macros shared by the glitch row generator
`ifndef HASHED_GLITCH_ROW_GENERATOR_MACROS_SVH
`define HASHED_GLITCH_ROW_GENERATOR_MACROS_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define HGR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HGR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/hgr_pkg.sv -----
// shared types, constants and codes of the glitch row generator
package hgr_pkg;

	localparam int unsigned ROWS_MAX_DEF = 3;
	localparam int unsigned SLOT_MS_DEF  = 100;

	localparam logic [31:0] C_MIX1 = 32'h7FEB352D;
	localparam logic [31:0] C_MIX2 = 32'h846CA68B;
	localparam logic [31:0] C_SEED = 32'h85EBCA6B;
	localparam logic [31:0] C_GOLD = 32'h9E3779B9;
	localparam logic [3:0]  PHASE_MASK = 4'hF;
	localparam logic [18:0] W_MAX = 19'd255;

	localparam int unsigned IN_W   = 128;
	localparam int unsigned OUT_W  = 48;
	localparam int unsigned DVD_W  = 32;
	localparam int unsigned DSR_W  = 17;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_LOAD_INV,
		OP_DIV,
		OP_SEED,
		OP_MIX,
		OP_H1,
		OP_H2,
		OP_H3,
		OP_H0,
		OP_RSEED,
		OP_OUT,
		OP_NEXT
	} op_t;

	typedef enum logic [2:0] {
		D_SLOT,
		D_ROWS,
		D_LO,
		D_HI,
		D_Y,
		D_W,
		D_X
	} dsel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_SLOT,
		S_DWAIT,
		S_SEED,
		S_MIX,
		S_H1,
		S_H2,
		S_H3,
		S_H0,
		S_ROWS,
		S_RSEED,
		S_LO,
		S_HI,
		S_Y,
		S_W,
		S_X,
		S_OUT,
		S_EMIT
	} state_t;

	typedef struct packed {
		op_t   op;
		dsel_t dsel;
	} cmd_t;

	typedef struct packed {
		logic inv;
		logic div_done;
		logic last;
	} sts_t;

endpackage

// ----- src/hashed_glitch_row_generator.sv -----
// top level: hashed glitch row generator with stream ports
// order of work: the time slot is divided and hashed, then the row count is divided out, then each row
// word is built and offered in turn, each row word waiting until the receiver takes it
// one request at a time: a new request is taken only after the last row word of the current one is taken
// the 32-step serial divider sets the pace: two divisions for the request head, five per row
// reset (arst_n low, asynchronous) returns the sequencer to idle with no word pending
`include "hashed_glitch_row_generator_macros.svh"

module hashed_glitch_row_generator
	import hgr_pkg::*;
#(
	parameter int unsigned ROWS_MAX = ROWS_MAX_DEF,
	parameter int unsigned SLOT_MS  = SLOT_MS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// request word
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// rect_x0, rect_y0, rect_x1, rect_y1, now_ms, seed
	input  logic [IN_W-1:0]  s_axis_tdata,
	// row word
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// row_x, row_y, row_w, row_phase, zero pad
	output logic [OUT_W-1:0] m_axis_tdata,
	// row_valid
	output logic             m_axis_tuser,
	output logic             m_axis_tlast
);

	cmd_t        cmd;
	sts_t        sts;
	logic        row_valid;
	logic [15:0] row_x, row_y;
	logic [7:0]  row_w;
	logic [3:0]  row_phase;

	// sequencer: one request in flight, each division waits for the serial divider
	hgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// operand registers, hash multiplier, divider and final clamp
	hgr_dp #(
		.ROWS_MAX (ROWS_MAX),
		.SLOT_MS  (SLOT_MS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_data (s_axis_tdata),
		.sts     (sts),
		.o_valid (row_valid),
		.o_x     (row_x),
		.o_y     (row_y),
		.o_w     (row_w),
		.o_phase (row_phase)
	);

	// output word comes straight from the datapath output register
	assign m_axis_tdata = {4'b0000, row_phase, row_w, row_y, row_x};
	assign m_axis_tuser = row_valid;
	assign m_axis_tlast = sts.last;

	// the block never offers a row while it is taking a request
	`HGR_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid, "ready while row pending")
	// dropped rows carry all-zero data
	`HGR_ASSERT_NOW(a_drop_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
		"dropped row with nonzero data")
	// a drawable row is at least one pixel wide
	`HGR_ASSERT_NOW(a_width_nz, m_axis_tvalid && m_axis_tuser, m_axis_tdata[39:32] != 8'd0,
		"drawable row of zero width")
	// after the last row goes out the block is ready for the next request
	`HGR_ASSERT_NEXT(a_back_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast,
		s_axis_tready, "not idle after last row")

endmodule

// ----- src/hgr_div.sv -----
// restoring divider, one quotient bit per cycle
module hgr_div
	import hgr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot,
	output logic [DSR_W-1:0] rem
);

	localparam int unsigned CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DSR_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[DSR_W-1:0];
			end
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

// ----- src/hgr_dp.sv -----
// datapath: operand registers, hash and row-bound multipliers, divider and row clamp
module hgr_dp
	import hgr_pkg::*;
#(
	parameter int unsigned ROWS_MAX = ROWS_MAX_DEF,
	parameter int unsigned SLOT_MS  = SLOT_MS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cmd_t            cmd,
	input  logic [IN_W-1:0] in_data,
	output sts_t            sts,
	output logic            o_valid,
	output logic [15:0]     o_x,
	output logic [15:0]     o_y,
	output logic [7:0]      o_w,
	output logic [3:0]      o_phase
);

	localparam int unsigned IW = $clog2(ROWS_MAX + 1);
	localparam int unsigned PW = IW + DSR_W;

	logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
	logic [31:0]        now_q, seed_q;
	logic [31:0]        slot_q, v_q, h0_q;
	logic [IW-1:0]      n_q, i_q;
	logic [DSR_W-1:0]   lo_q, hi_q;
	logic [17:0]        w_q;
	logic signed [18:0] x_q, y_q;
	dsel_t              dsel_q;
	logic               last_q;

	logic               div_start;
	logic [DVD_W-1:0]   div_dvd;
	logic [DSR_W-1:0]   div_dsr;
	logic               div_done;
	logic [DVD_W-1:0]   div_quot;
	logic [DSR_W-1:0]   div_rem;

	logic signed [17:0] span_x18, span_y18;
	logic [DSR_W-1:0]   span_x, span_y, half, stripe;
	logic [IW-1:0]      ip1, nr;
	logic [PW-1:0]      prod_lo, prod_hi;
	logic signed [18:0] x0e, y0e, x1e, y1e, xc, yc, wt, wc;
	logic               inv;
	logic [17:0]        half_sum;

	assign inv = (x1_q < x0_q) || (y1_q < y0_q);
	assign span_x18 = 18'(x1_q) - 18'(x0_q) + 18'sd1;
	assign span_y18 = 18'(y1_q) - 18'(y0_q) + 18'sd1;
	assign span_x   = span_x18[DSR_W-1:0];
	assign span_y   = span_y18[DSR_W-1:0];
	assign half_sum = {1'b0, span_x} + 18'd1;
	assign half     = half_sum[17:1];
	assign stripe   = (hi_q > lo_q) ? (hi_q - lo_q) : DSR_W'(1);

	assign ip1     = i_q + IW'(1);
	assign prod_lo = PW'(span_y) * PW'(i_q);
	assign prod_hi = PW'(span_y) * PW'(ip1);

	always_comb begin
		div_start = (cmd.op == OP_DIV);
		div_dvd   = '0;
		div_dsr   = DSR_W'(1);
		unique case (cmd.dsel)
			D_SLOT: begin
				div_dvd = now_q;
				div_dsr = DSR_W'(SLOT_MS);
			end
			D_ROWS: begin
				div_dvd = h0_q;
				div_dsr = DSR_W'(ROWS_MAX);
			end
			D_LO: begin
				div_dvd = DVD_W'(prod_lo);
				div_dsr = DSR_W'(n_q);
			end
			D_HI: begin
				div_dvd = DVD_W'(prod_hi);
				div_dsr = DSR_W'(n_q);
			end
			D_Y: begin
				div_dvd = v_q >> 8;
				div_dsr = stripe;
			end
			D_W: begin
				div_dvd = v_q >> 3;
				div_dsr = span_x - half + DSR_W'(1);
			end
			D_X: begin
				div_dvd = v_q >> 19;
				div_dsr = DSR_W'({1'b0, span_x} - w_q + 18'd1);
			end
			default: begin
				div_dvd = '0;
				div_dsr = DSR_W'(1);
			end
		endcase
	end

	hgr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// row count from the remainder, capped by the rectangle height
	assign nr = IW'(div_rem) + IW'(1);

	// clamp of the finished row
	assign x0e = 19'(x0_q);
	assign y0e = 19'(y0_q);
	assign x1e = 19'(x1_q);
	assign y1e = 19'(y1_q);

	always_comb begin
		yc = y_q;
		if (yc < y0e) yc = y0e;
		if (yc > y1e) yc = y1e;
		xc = x_q;
		if (xc < x0e) xc = x0e;
		if (xc > x1e) xc = x1e;
		wt = $signed({1'b0, w_q});
		if (xc + wt - 19'sd1 > x1e) wt = x1e - xc + 19'sd1;
		wc = wt;
		if (wc < 19'sd1) wc = 19'sd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q <= D_SLOT;
			last_q <= 1'b0;
			o_valid <= 1'b0;
		end else begin
			if (cmd.op == OP_DIV) dsel_q <= cmd.dsel;
			if (cmd.op == OP_LOAD_INV) begin
				last_q  <= 1'b1;
				o_valid <= 1'b0;
			end else if (cmd.op == OP_OUT) begin
				last_q  <= (ip1 == n_q);
				o_valid <= (wc <= $signed(W_MAX));
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				x0_q   <= in_data[15:0];
				y0_q   <= in_data[31:16];
				x1_q   <= in_data[47:32];
				y1_q   <= in_data[63:48];
				now_q  <= in_data[95:64];
				seed_q <= in_data[127:96];
			end
			OP_LOAD_INV: begin
				o_x     <= '0;
				o_y     <= '0;
				o_w     <= '0;
				o_phase <= '0;
			end
			OP_SEED:  v_q <= seed_q * C_SEED;
			OP_MIX:   v_q <= slot_q ^ v_q;
			OP_H1:    v_q <= (v_q ^ (v_q >> 16)) * C_MIX1;
			OP_H2:    v_q <= (v_q ^ (v_q >> 15)) * C_MIX2;
			OP_H3:    v_q <= v_q ^ (v_q >> 16);
			OP_H0:    h0_q <= v_q;
			OP_RSEED: v_q <= h0_q + C_GOLD * 32'(ip1);
			OP_NEXT:  i_q <= ip1;
			OP_OUT: begin
				if (wc <= $signed(W_MAX)) begin
					o_x     <= xc[15:0];
					o_y     <= yc[15:0];
					o_w     <= wc[7:0];
					o_phase <= v_q[27:24] & PHASE_MASK;
				end else begin
					o_x     <= '0;
					o_y     <= '0;
					o_w     <= '0;
					o_phase <= '0;
				end
			end
			default: ;
		endcase
		if (div_done) begin
			unique case (dsel_q)
				D_SLOT: slot_q <= div_quot;
				D_ROWS: begin
					n_q <= (span_y < DSR_W'(nr)) ? span_y[IW-1:0] : nr;
					i_q <= '0;
				end
				D_LO: lo_q <= div_quot[DSR_W-1:0];
				D_HI: hi_q <= div_quot[DSR_W-1:0];
				D_Y:  y_q  <= y0e + 19'(lo_q) + 19'(div_rem);
				D_W:  w_q  <= 18'(half) + 18'(div_rem);
				D_X:  x_q  <= x0e + 19'(div_rem);
				default: ;
			endcase
		end
	end

	assign sts.inv      = inv;
	assign sts.div_done = div_done;
	assign sts.last     = last_q;

endmodule

// ----- src/hgr_ctrl.sv -----
// controller: sequences the hash, divisions and row emission
module hgr_ctrl
	import hgr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic   row_q, row_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			row_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			row_q   <= row_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		row_d   = row_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
					row_d   = 1'b0;
				end
			end
			S_CHECK: state_d = sts.inv ? S_EMIT : S_SLOT;
			S_SLOT: begin
				state_d = S_DWAIT;
				ret_d   = S_SEED;
			end
			S_DWAIT: begin
				if (sts.div_done) state_d = ret_q;
			end
			S_SEED: state_d = S_MIX;
			S_MIX:  state_d = S_H1;
			S_H1:   state_d = S_H2;
			S_H2:   state_d = S_H3;
			S_H3:   state_d = row_q ? S_LO : S_H0;
			S_H0:   state_d = S_ROWS;
			S_ROWS: begin
				state_d = S_DWAIT;
				ret_d   = S_RSEED;
			end
			S_RSEED: begin
				state_d = S_H1;
				row_d   = 1'b1;
			end
			S_LO: begin
				state_d = S_DWAIT;
				ret_d   = S_HI;
			end
			S_HI: begin
				state_d = S_DWAIT;
				ret_d   = S_Y;
			end
			S_Y: begin
				state_d = S_DWAIT;
				ret_d   = S_W;
			end
			S_W: begin
				state_d = S_DWAIT;
				ret_d   = S_X;
			end
			S_X: begin
				state_d = S_DWAIT;
				ret_d   = S_OUT;
			end
			S_OUT: state_d = S_EMIT;
			S_EMIT: begin
				if (out_ready) state_d = sts.last ? S_IDLE : S_RSEED;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.dsel  = D_SLOT;
		in_ready  = (state_q == S_IDLE);
		out_valid = (state_q == S_EMIT);
		unique case (state_q)
			S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
			S_CHECK: if (sts.inv) cmd.op = OP_LOAD_INV;
			S_SLOT: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_SLOT;
			end
			S_SEED:  cmd.op = OP_SEED;
			S_MIX:   cmd.op = OP_MIX;
			S_H1:    cmd.op = OP_H1;
			S_H2:    cmd.op = OP_H2;
			S_H3:    cmd.op = OP_H3;
			S_H0:    cmd.op = OP_H0;
			S_ROWS: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_ROWS;
			end
			S_RSEED: cmd.op = OP_RSEED;
			S_LO: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_LO;
			end
			S_HI: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_HI;
			end
			S_Y: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_Y;
			end
			S_W: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_W;
			end
			S_X: begin
				cmd.op   = OP_DIV;
				cmd.dsel = D_X;
			end
			S_OUT:   cmd.op = OP_OUT;
			S_EMIT:  if (out_ready) cmd.op = OP_NEXT;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ----- tb/tb.sv -----
// testbench for the hashed glitch row generator: directed table, then random requests
module tb;
	import hgr_pkg::*;

	localparam int unsigned ROWS = 3;
	localparam int unsigned SLOT = 100;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic               ok;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         w;
		logic [3:0]         phase;
		logic               last;
	} row_t;

	typedef struct {
		logic signed [15:0] x0, y0, x1, y1;
		logic [31:0] now, seed;
		logic        typed;   // expected rows below are typed in
		row_t        row0;    // single expected word when typed
	} req_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser, m_axis_tlast;

	row_t expected_rows[$];
	int errors = 0;
	int idle_cycles = 0;
	bit rx_no_stall = 0;
	bit rx_hold = 0;

	hashed_glitch_row_generator dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] murmur_mix(logic [31:0] v);
		v = v ^ (v >> 16); v = v * 32'h7FEB352D;
		v = v ^ (v >> 15); v = v * 32'h846CA68B;
		v = v ^ (v >> 16);
		return v;
	endfunction

	// predicted rows of one request pushed onto the expectation queue
	task automatic predict_rows(req_t r);
		int x0, y0, x1, y1, span_x, span_y, half, lo, hi, stripe, x, y, w;
		logic [31:0] h0, h, n;
		row_t o;
		x0 = int'(r.x0); y0 = int'(r.y0); x1 = int'(r.x1); y1 = int'(r.y1);
		if (x1 < x0 || y1 < y0) begin
			expected_rows.push_back('{1'b0, 16'sd0, 16'sd0, 8'd0, 4'd0, 1'b1});
			return;
		end
		span_x = x1 - x0 + 1;
		span_y = y1 - y0 + 1;
		h0 = murmur_mix((r.now / SLOT) ^ (r.seed * 32'h85EBCA6B));
		n = 1 + (h0 % ROWS);
		if (n > span_y) n = span_y;
		half = (span_x + 1) / 2;
		for (int unsigned i = 0; i < n; i++) begin
			h = murmur_mix(h0 + 32'h9E3779B9 * (i + 1));
			lo = y0 + int'(i * span_y / n);
			hi = y0 + int'((i + 1) * span_y / n) - 1;
			stripe = (hi >= lo) ? hi - lo + 1 : 1;
			y = lo + int'((h >> 8) % stripe);
			w = half + int'((h >> 3) % (span_x - half + 1));
			x = x0 + int'((h >> 19) % (span_x - w + 1));
			if (y < y0) y = y0;
			if (y > y1) y = y1;
			if (x < x0) x = x0;
			if (x > x1) x = x1;
			if (x + w - 1 > x1) w = x1 - x + 1;
			if (w < 1) w = 1;
			o.last = (i + 1 == n);
			if (w > 255) begin
				o.ok = 1'b0; o.x = '0; o.y = '0; o.w = '0; o.phase = '0;
			end else begin
				o.ok = 1'b1; o.x = x[15:0]; o.y = y[15:0]; o.w = w[7:0];
				o.phase = h[27:24];
			end
			expected_rows.push_back(o);
		end
	endtask

	task automatic report_mismatch(string what, row_t got, row_t want);
		errors++;
		$display("mismatch %s: got %p want %p", what, got, want);
	endtask

	// sender: one request word, with random gaps unless gaps is cleared (hold-off phase and final stretch)
	task automatic send_request(req_t r, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 10)) @(negedge clk);
		@(negedge clk);
		if (r.typed) expected_rows.push_back(r.row0);
		else predict_rows(r);
		s_axis_tdata <= {r.seed, r.now, r.y1, r.x1, r.y0, r.x0};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	function automatic req_t rand_request();
		req_t r;
		int sx, sy;
		r.typed = 0; r.row0 = '0;
		r.now = $urandom; r.seed = $urandom;
		case ($urandom_range(0, 9))
			0: begin   // anything at all, often inverted or huge
				r.x0 = 16'($urandom); r.y0 = 16'($urandom);
				r.x1 = 16'($urandom); r.y1 = 16'($urandom);
			end
			1: begin   // wide rectangle, rows may be too wide
				sx = $urandom_range(200, 2000); sy = $urandom_range(1, 40);
				r.x0 = 16'($urandom_range(0, 60000) - 32768);
				r.y0 = 16'($urandom_range(0, 60000) - 32768);
				r.x1 = 16'(r.x0 + sx); r.y1 = 16'(r.y0 + sy);
				if (r.x1 < r.x0) r.x1 = 16'sh7FFF;
				if (r.y1 < r.y0) r.y1 = 16'sh7FFF;
			end
			default: begin   // sprite sized
				sx = $urandom_range(0, 300); sy = $urandom_range(0, 6);
				if ($urandom_range(0, 1)) sy = $urandom_range(0, 200);
				r.x0 = 16'($urandom); r.y0 = 16'($urandom);
				r.x1 = 16'(r.x0 + sx); r.y1 = 16'(r.y0 + sy);
				if (r.x1 < r.x0) r.x1 = 16'sh7FFF;
				if (r.y1 < r.y0) r.y1 = 16'sh7FFF;
			end
		endcase
		return r;
	endfunction

	function automatic req_t mk(int x0, int y0, int x1, int y1, logic [31:0] now,
		logic [31:0] seed, bit typed = 0);
		req_t r;
		r.x0 = 16'(x0); r.y0 = 16'(y0); r.x1 = 16'(x1); r.y1 = 16'(y1);
		r.now = now; r.seed = seed;
		r.typed = typed;
		r.row0 = '{1'b0, 16'sd0, 16'sd0, 8'd0, 4'd0, 1'b1};   // inverted rectangle word
		return r;
	endfunction

	// receiver: random stalls, long hold-off on request, checks each word
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) m_axis_tready <= 0;
			else if (!rx_no_stall && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else m_axis_tready <= 1;
		end
	end

	always @(posedge clk) begin
		row_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
				m_axis_tdata[39:32], m_axis_tdata[43:40], m_axis_tlast};
			if (expected_rows.size() == 0) begin
				report_mismatch("unexpected row word", got, '0);
			end else begin
				want = expected_rows.pop_front();
				if (got !== want) report_mismatch("row word", got, want);
			end
		end
	end

	// watchdog on cycles with no handshake at all, paused while the receiver holds off
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rx_hold)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		req_t table_rows[$];
		arst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: inverted rectangles typed in, extremes through the predictor
		table_rows = '{
			mk(10, 0, 9, 5, 0, 0, 1),
			mk(0, 10, 5, 9, 32'hFFFFFFFF, 32'hFFFFFFFF, 1),
			mk(32767, -32768, -32768, 32767, 123, 456, 1),
			mk(0, 0, 0, 0, 0, 0),
			mk(-32768, -32768, -32768, -32768, 32'hFFFFFFFF, 0),
			mk(32767, 32767, 32767, 32767, 0, 32'hFFFFFFFF),
			mk(-32768, -32768, 32767, 32767, 99, 1),
			mk(-32768, -32768, 32767, 32767, 100, 1),
			mk(0, 0, 255, 10, 5000, 7),
			mk(0, 0, 254, 10, 5000, 7),
			mk(0, 0, 600, 2, 12345, 8),
			mk(-5, -5, 5, 0, 777, 3),
			mk(0, 0, 3, 1, 42, 42),
			mk(100, 100, 163, 163, 32'h80000000, 32'h12345678),
			mk(0, 0, 1, 300, 0, 32'hDEADBEEF)
		};
		foreach (table_rows[i]) send_request(table_rows[i], 1);
		// receiver holds off while requests keep coming
		rx_hold = 1;
		fork
			begin
				repeat (2000) @(posedge clk);
				rx_hold = 0;
			end
			repeat (6) send_request(rand_request(), 0);
		join
		for (int i = 0; i < 300; i++) begin
			if (i == 150) wait (expected_rows.size() == 0);
			send_request(rand_request(), 1);
		end
		rx_no_stall = 1;
		for (int i = 0; i < 60; i++) send_request(rand_request(), 0);
		wait (expected_rows.size() == 0);
		repeat (700) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/hgr_pkg.sv
src/hgr_div.sv
src/hgr_dp.sv
src/hgr_ctrl.sv
src/hashed_glitch_row_generator.sv
tb/tb.sv
